@@ src/rhh_pkg.sv @@
package rhh_pkg;

    // Slot marks
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_OCC   = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    // Actions
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_ERASED   = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // SplitMix64 constants
    localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;

    localparam int unsigned MAX_USED_W     = 10;
    localparam logic [9:0]  MAX_USED_RESET = 10'd819;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [63:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] value_out;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_EVAL, S_RESP
    } t_state;

    typedef enum logic [2:0] {
        H_IDLE, H_PRE, H_MUL, H_FIN, H_DONE
    } t_hash_state;

endpackage

@@ src/rhh_hash.sv @@
// SplitMix64 on one shared 32x32 multiplier; the home slot is the low bits of
// the hash (CAPACITY is a power of two).
module rhh_hash import rhh_pkg::*; #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [63:0]                 i_key,
    output logic                        o_done,
    output logic [$clog2(CAPACITY)-1:0] o_idx
);
    localparam int unsigned AW = $clog2(CAPACITY);

    t_hash_state r_state, n_state;
    logic [63:0] r_x, r_t, r_acc;
    logic [1:0]  r_step;
    logic        r_phase;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] mconst;

    // Shared multiplier operand selection (low 64 bits of a 64x64 product)
    always_comb begin
        mconst = r_phase ? MIX_MUL2 : MIX_MUL1;
        mul_a  = (r_step == 2'd2) ? r_t[63:32] : r_t[31:0];
        mul_b  = (r_step == 2'd1) ? mconst[63:32] : mconst[31:0];
        prod   = {32'd0, mul_a} * {32'd0, mul_b};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_IDLE: if (i_start) n_state = H_PRE;
            H_PRE:  n_state = H_MUL;
            H_MUL: begin
                if (r_step == 2'd2) n_state = r_phase ? H_FIN : H_PRE;
            end
            H_FIN:  n_state = H_DONE;
            H_DONE: n_state = H_IDLE;
            default: n_state = H_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_done = (r_state == H_DONE);
        o_idx  = r_x[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            H_IDLE: begin
                r_x     <= i_key + MIX_ADD;
                r_phase <= 1'b0;
            end
            H_PRE: begin
                r_t    <= r_phase ? (r_acc ^ (r_acc >> 27)) : (r_x ^ (r_x >> 30));
                r_step <= 2'd0;
            end
            H_MUL: begin
                if (r_step == 2'd0) begin
                    r_acc <= prod;
                end else begin
                    r_acc[63:32] <= r_acc[63:32] + prod[31:0];
                end
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) r_phase <= 1'b1;
            end
            H_FIN: begin
                r_x <= r_acc ^ (r_acc >> 31);
            end
            H_DONE: ;
            default: ;
        endcase
    end

endmodule

@@ src/robin_hood_hash_table_top.sv @@
// Robin Hood hash map, CAPACITY slots of 64-bit key and value; CAPACITY must be
// a power of two, as the home slot is the low hash bits. After reset the
// block sweeps the slot marks to empty and takes no transaction meanwhile
// (max_used writes are taken at any time). An operation then runs one at a
// time: the transaction is taken, the key is hashed on a shared 32x32
// multiplier, then each probed slot gets a registered read of the slot
// memories and then a compare and write, then the result goes to the output
// register, waiting while it is held by a stalled result. Probing is skipped
// for an insert over the load limit, hashing too for an unknown action.
module robin_hood_hash_table_top import rhh_pkg::*; #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [MAX_USED_W-1:0] i_cfg_wdata
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned DW = AW + 2;
    localparam int unsigned EW = 128 + DW;
    localparam int unsigned SW = CW + MAX_USED_W + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    // Slot storage
    logic [1:0]    mark_mem [CAPACITY];
    logic [EW-1:0] ent_mem  [CAPACITY];
    logic [1:0]    r_mark_q;
    logic [EW-1:0] r_ent_q;

    t_state r_state, n_state;
    logic [MAX_USED_W-1:0] r_max_used;
    logic [CW-1:0] r_live, r_tomb;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_n;
    logic [DW-1:0] r_cd;
    logic [1:0]    r_action;
    logic [63:0]   r_key, r_val, r_ck, r_cv;
    logic [2:0]    r_status;
    logic [63:0]   r_vout;
    t_out_item     r_out;
    logic          r_out_valid;
    logic          r_hash_busy;

    logic          accept, hash_start, hash_done, full, out_free, last_probe;
    logic [AW-1:0] hash_idx;
    logic [63:0]   q_key, q_val;
    logic [DW-1:0] q_dist;

    // Evaluation decisions
    logic          ev_end, ev_wr_mark, ev_wr_ent, ev_swap;
    logic          ev_live_inc, ev_live_dec, ev_tomb_inc, ev_tomb_dec;
    logic [1:0]    ev_mark;
    logic [EW-1:0] ev_ent;
    logic [2:0]    ev_status;
    logic [63:0]   ev_vout;

    rhh_hash #(.CAPACITY(CAPACITY)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (r_key),
        .o_done  (hash_done),
        .o_idx   (hash_idx)
    );

    assign {q_key, q_val, q_dist} = r_ent_q;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_probe = (r_n == CW'(CAPACITY - 1));
    assign full = (SW'(r_live) + SW'(r_tomb) > SW'(r_max_used)) ||
                  (r_live >= CW'(CAPACITY));

    // Slot decision for the current probe
    always_comb begin
        ev_end = 1'b0; ev_wr_mark = 1'b0; ev_wr_ent = 1'b0; ev_swap = 1'b0;
        ev_live_inc = 1'b0; ev_live_dec = 1'b0; ev_tomb_inc = 1'b0; ev_tomb_dec = 1'b0;
        ev_mark = MARK_OCC;
        ev_ent = {r_ck, r_cv, r_cd};
        ev_status = ST_MISSING;
        ev_vout = 64'd0;
        if (r_action == ACT_INSERT) begin
            if (r_mark_q != MARK_OCC) begin
                ev_end = 1'b1; ev_wr_mark = 1'b1; ev_wr_ent = 1'b1;
                ev_live_inc = 1'b1;
                ev_tomb_dec = (r_mark_q == MARK_TOMB) && (r_tomb != '0);
                ev_status = ST_NEW;
            end else if (q_key == r_key) begin
                ev_end = 1'b1; ev_wr_ent = 1'b1;
                ev_ent = {q_key, r_val, q_dist};
                ev_status = ST_REPLACED;
            end else begin
                if (q_dist < r_cd) begin
                    ev_swap = 1'b1; ev_wr_ent = 1'b1;
                end
                ev_end = last_probe;
                ev_status = ST_FULL;
            end
        end else begin
            if (r_mark_q == MARK_EMPTY) begin
                ev_end = 1'b1;
            end else if (r_mark_q == MARK_OCC && q_key == r_key) begin
                ev_end = 1'b1;
                if (r_action == ACT_ERASE) begin
                    ev_wr_mark = 1'b1; ev_mark = MARK_TOMB;
                    ev_live_dec = (r_live != '0); ev_tomb_inc = 1'b1;
                    ev_status = ST_ERASED;
                end else begin
                    ev_status = ST_FOUND;
                end
                ev_vout = q_val;
            end else if (r_mark_q == MARK_OCC && q_dist < r_cd) begin
                ev_end = 1'b1;
            end else begin
                ev_end = last_probe;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_idx == LAST_IDX) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in.action == ACT_INSERT || i_in.action == ACT_LOOKUP ||
                               i_in.action == ACT_ERASE) ? S_HASH : S_RESP;
                end
            end
            S_HASH: begin
                if (hash_done) n_state = (r_action == ACT_INSERT && full) ? S_RESP : S_READ;
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: n_state = ev_end ? S_RESP : S_READ;
            S_RESP: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        accept     = i_in_valid && (r_state == S_IDLE);
        hash_start = (r_state == S_HASH) && !r_hash_busy;
        o_out_valid = r_out_valid;
        o_out       = r_out;
    end

    // Start the hash unit on the first hash cycle only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_busy <= 1'b0;
        end else begin
            r_hash_busy <= (r_state == S_HASH) && !hash_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_max_used  <= MAX_USED_RESET;
            r_live      <= '0;
            r_tomb      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_max_used <= i_cfg_wdata;
            if (r_state == S_EVAL) begin
                if (ev_live_inc) r_live <= r_live + CW'(1);
                if (ev_live_dec) r_live <= r_live - CW'(1);
                if (ev_tomb_inc) r_tomb <= r_tomb + CW'(1);
                if (ev_tomb_dec) r_tomb <= r_tomb - CW'(1);
            end
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + AW'(1);
                S_IDLE: begin
                    if (accept) begin
                        r_action <= i_in.action;
                        r_key    <= i_in.key;
                        r_val    <= i_in.value_in;
                        r_status <= ST_MISSING;
                        r_vout   <= 64'd0;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_idx    <= hash_idx;
                        r_cd     <= DW'(1);
                        r_n      <= '0;
                        r_ck     <= r_key;
                        r_cv     <= r_val;
                        r_status <= ST_FULL;
                    end
                end
                S_READ: ;
                S_EVAL: begin
                    r_status <= ev_status;
                    r_vout   <= ev_vout;
                    if (ev_swap) begin
                        r_ck <= q_key;
                        r_cv <= q_val;
                        r_cd <= q_dist + DW'(1);
                    end else begin
                        r_cd <= r_cd + DW'(1);
                    end
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + AW'(1);
                    r_n   <= r_n + CW'(1);
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out.status    <= r_status;
                        r_out.value_out <= r_vout;
                    end
                end
                default: ;
            endcase
        end
    end

    // Slot memories: registered reads, one write port each
    always_ff @(posedge i_clk) begin
        r_mark_q <= mark_mem[r_idx];
        r_ent_q  <= ent_mem[r_idx];
        if (r_state == S_CLEAR) begin
            mark_mem[r_idx] <= MARK_EMPTY;
        end else if (r_state == S_EVAL && ev_wr_mark) begin
            mark_mem[r_idx] <= ev_mark;
        end
        if (r_state == S_EVAL && ev_wr_ent) begin
            ent_mem[r_idx] <= ev_ent;
        end
    end

endmodule

@@ src/rhh_checker.sv @@
module rhh_checker import rhh_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);
    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // One operation at a time: busy right after a transaction is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // Status stays within the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status <= ST_FULL)
        else $error("bad status");

    // Value only with found or erased
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_FOUND && o_out.status != ST_ERASED
        |-> o_out.value_out == 64'd0)
        else $error("value without hit");
endmodule

bind robin_hood_hash_table_top rhh_checker u_rhh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import rhh_pkg::*;

    localparam int          SLOTS      = 1024;
    localparam int          LIMIT      = 1500000;
    localparam int          KEY_POOL_N = 96;
    localparam logic [1:0]  ACT_SPARE  = 2'd3;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    t_in_item        i_in = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out_item       o_out;
    logic            i_cfg_we = 1'b0;
    logic [9:0]      i_cfg_wdata = '0;

    robin_hood_hash_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the table
    logic [1:0]  tbl_mark [SLOTS];
    logic [63:0] tbl_key  [SLOTS];
    logic [63:0] tbl_val  [SLOTS];
    logic [63:0] tbl_hash [SLOTS];
    int unsigned tbl_dist [SLOTS];
    int unsigned n_live;
    int unsigned n_tomb;
    int unsigned load_cap;

    t_out_item   pending_results[$];
    logic [63:0] key_pool[KEY_POOL_N];
    int          n_errors = 0;
    int          cycle_cnt = 0;
    bit          hold_req = 1'b0;

    function automatic logic [63:0] splitmix(input logic [63:0] k);
        logic [63:0] x;
        x = k + 64'h9e3779b97f4a7c15;
        x = (x ^ (x >> 30)) * 64'hbf58476d1ce4e5b9;
        x = (x ^ (x >> 27)) * 64'h94d049bb133111eb;
        return x ^ (x >> 31);
    endfunction

    // Slot holding key, or -1 when the probe run ends without a match
    function automatic int probe_find(input logic [63:0] k);
        logic [63:0] h;
        int          idx;
        int unsigned d;
        h = splitmix(k);
        idx = int'(h % SLOTS);
        d = 1;
        for (int n = 0; n < SLOTS; n++) begin
            if (tbl_mark[idx] == MARK_EMPTY) return -1;
            if (tbl_mark[idx] == MARK_OCC) begin
                if (tbl_hash[idx] == h && tbl_key[idx] == k) return idx;
                if (tbl_dist[idx] < d) return -1;
            end
            idx = (idx + 1) % SLOTS;
            d++;
        end
        return -1;
    endfunction

    function automatic logic [2:0] table_insert(input logic [63:0] k, input logic [63:0] v);
        logic [63:0] ck, cv, ch, tk, tv, th;
        int unsigned cd, td;
        int          idx;
        if (n_live + n_tomb > load_cap || n_live >= SLOTS) return ST_FULL;
        ck = k; cv = v; ch = splitmix(k); cd = 1;
        idx = int'(ch % SLOTS);
        for (int n = 0; n < SLOTS; n++) begin
            if (tbl_mark[idx] != MARK_OCC) begin
                if (tbl_mark[idx] == MARK_TOMB && n_tomb > 0) n_tomb--;
                tbl_mark[idx] = MARK_OCC;
                tbl_key[idx] = ck; tbl_val[idx] = cv;
                tbl_hash[idx] = ch; tbl_dist[idx] = cd;
                n_live++;
                return ST_NEW;
            end
            if (tbl_hash[idx] == ch && tbl_key[idx] == k) begin
                tbl_val[idx] = v;
                return ST_REPLACED;
            end
            // Robin Hood swap: the poorer entry takes the slot
            if (tbl_dist[idx] < cd) begin
                tk = tbl_key[idx]; tv = tbl_val[idx]; th = tbl_hash[idx]; td = tbl_dist[idx];
                tbl_key[idx] = ck; tbl_val[idx] = cv; tbl_hash[idx] = ch; tbl_dist[idx] = cd;
                ck = tk; cv = tv; ch = th; cd = td;
            end
            idx = (idx + 1) % SLOTS;
            cd++;
        end
        return ST_FULL;
    endfunction

    function automatic t_out_item table_apply(input t_in_item it);
        t_out_item r;
        int        pos;
        r.status = ST_MISSING;
        r.value_out = '0;
        if (it.action == ACT_INSERT) begin
            r.status = table_insert(it.key, it.value_in);
        end else if (it.action == ACT_LOOKUP || it.action == ACT_ERASE) begin
            pos = probe_find(it.key);
            if (pos >= 0) begin
                r.value_out = tbl_val[pos];
                if (it.action == ACT_LOOKUP) begin
                    r.status = ST_FOUND;
                end else begin
                    r.status = ST_ERASED;
                    tbl_mark[pos] = MARK_TOMB;
                    tbl_val[pos] = '0; tbl_hash[pos] = '0; tbl_dist[pos] = 0;
                    if (n_live > 0) n_live--;
                    n_tomb++;
                end
            end
        end
        return r;
    endfunction

    // Offer one transaction, hold it until taken, queue its expected result
    task automatic offer_op(input t_in_item it, input bit fixed, input t_out_item want);
        t_out_item pred;
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        pred = table_apply(it);
        pending_results.push_back(fixed ? want : pred);
    endtask

    task automatic idle_gap(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_load_cap(input logic [9:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        load_cap = v;
    endtask

    function automatic t_in_item rand_op();
        t_in_item    it;
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 45)      it.action = ACT_INSERT;
        else if (p < 78) it.action = ACT_LOOKUP;
        else if (p < 95) it.action = ACT_ERASE;
        else             it.action = ACT_SPARE;
        if ($urandom_range(0, 99) < 80) it.key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        else                            it.key = {$urandom, $urandom};
        it.value_in = {$urandom, $urandom};
        return it;
    endfunction

    // Random traffic sent in bursts with random gaps
    task automatic random_ops(input int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
            end
            offer_op(rand_op(), 1'b0, '0);
            burst--;
        end
    endtask

    // Directed stimulus: typed expectation where check is set
    typedef struct {
        logic [1:0]  act;
        logic [63:0] key;
        logic [63:0] val;
        bit          check;
        logic [2:0]  st;
        logic [63:0] vout;
    } t_row;

    t_row dir_rows[] = '{
        '{ACT_LOOKUP, 64'd0,     64'd0,     1'b1, ST_MISSING,  64'd0},
        '{ACT_ERASE,  ALL_ONES,  64'd0,     1'b1, ST_MISSING,  64'd0},
        '{ACT_SPARE,  64'd5,     64'd7,     1'b1, ST_MISSING,  64'd0},
        '{ACT_INSERT, 64'd0,     ALL_ONES,  1'b1, ST_NEW,      64'd0},
        '{ACT_INSERT, 64'd0,     64'h1234,  1'b1, ST_REPLACED, 64'd0},
        '{ACT_LOOKUP, 64'd0,     64'd0,     1'b1, ST_FOUND,    64'h1234},
        '{ACT_INSERT, ALL_ONES,  64'd0,     1'b1, ST_NEW,      64'd0},
        '{ACT_LOOKUP, ALL_ONES,  ALL_ONES,  1'b1, ST_FOUND,    64'd0},
        '{ACT_ERASE,  64'd0,     64'd0,     1'b1, ST_ERASED,   64'h1234},
        '{ACT_LOOKUP, 64'd0,     64'd0,     1'b1, ST_MISSING,  64'd0},
        '{ACT_ERASE,  64'd0,     64'd0,     1'b1, ST_MISSING,  64'd0},
        '{ACT_INSERT, 64'd0,     ALL_ONES,  1'b0, ST_NEW,      64'd0},
        '{ACT_SPARE,  ALL_ONES,  ALL_ONES,  1'b1, ST_MISSING,  64'd0},
        '{ACT_INSERT, 64'h8000_0000_0000_0001, 64'h5555_AAAA_5555_AAAA, 1'b0, ST_NEW, 64'd0},
        '{ACT_LOOKUP, 64'h8000_0000_0000_0001, 64'd0, 1'b0, ST_FOUND, 64'd0},
        '{ACT_ERASE,  ALL_ONES,  64'd0,     1'b1, ST_ERASED,   64'd0},
        '{ACT_INSERT, ALL_ONES,  64'h0F0F,  1'b0, ST_NEW,      64'd0}
    };

    // Result checker and receiver stall pattern
    int unsigned stall_mode = 0;
    int unsigned hold_left = 0;
    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction status=%0d value=%h",
                         $time, o_out.status, o_out.value_out);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out.status);
                    n_errors++;
                end
                if (o_out.value_out !== want.value_out) begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, want.value_out, o_out.value_out);
                    n_errors++;
                end
            end
        end
        if (hold_req && hold_left == 0) hold_left <= 600;
        if (hold_left > 1) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            if (hold_left == 1) hold_left <= 0;
            if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item want;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_mark[i] = MARK_EMPTY;
            tbl_key[i] = '0; tbl_val[i] = '0; tbl_hash[i] = '0; tbl_dist[i] = 0;
        end
        n_live = 0;
        n_tomb = 0;
        load_cap = MAX_USED_RESET;
        for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset load limit
        foreach (dir_rows[i]) begin
            it.action = dir_rows[i].act;
            it.key = dir_rows[i].key;
            it.value_in = dir_rows[i].val;
            want.status = dir_rows[i].st;
            want.value_out = dir_rows[i].vout;
            offer_op(it, dir_rows[i].check, want);
        end
        drain_results();

        // Load limit of one: three live entries exceed it
        set_load_cap(10'd1);
        for (int i = 0; i < 3; i++) begin
            it.action = ACT_INSERT;
            it.key = {$urandom, $urandom};
            it.value_in = {$urandom, $urandom};
            want.status = ST_FULL;
            want.value_out = '0;
            offer_op(it, 1'b1, want);
        end
        random_ops(40);
        drain_results();

        // Highest limit, with a long receiver hold while traffic continues
        set_load_cap(10'd1023);
        hold_req = 1'b1;
        random_ops(30);
        hold_req = 1'b0;
        random_ops(300);
        drain_results();

        // Tight limit so inserts hit the full answer often
        set_load_cap(10'($urandom_range(20, 60)));
        random_ops(180);
        drain_results();

        set_load_cap(10'd819);
        random_ops(280);
        drain_results();

        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/rhh_pkg.sv
src/rhh_hash.sv
src/robin_hood_hash_table_top.sv
src/rhh_checker.sv
tb/tb.sv
